// ----- rtl/cardinal_spline_evaluator_core_defines.svh -----
// assertion macros for the cardinal spline evaluator
`ifndef CARDINAL_SPLINE_EVALUATOR_CORE_DEFINES_SVH
`define CARDINAL_SPLINE_EVALUATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CSE_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("cardinal spline evaluator check failed");
`define CSE_ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("cardinal spline evaluator forbidden condition");
`else
`define CSE_ASSERT(label, clk, rst_n, prop)
`define CSE_ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// ----- rtl/cse_pkg.sv -----
// shared constants and types of the cardinal spline evaluator
package cse_pkg;
    localparam int MAX_POINTS = 64;
    localparam int PT_AW      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int LATENCY    = 6;

    // command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    // register indexes
    localparam logic [1:0] REG_POINT_COUNT = 2'd0;
    localparam logic [1:0] REG_CLOSED_LOOP = 2'd1;
    localparam logic [1:0] REG_TENSION_S   = 2'd2;

    localparam logic [15:0] TENSION_RESET = 16'd16384;

    typedef logic signed [31:0] t_coord;
    typedef logic [PT_AW-1:0]   t_addr;
endpackage

// ----- rtl/cardinal_spline_evaluator_core.sv -----
// cardinal spline evaluator: point store and pipelined evaluation
//
//  channel  | handshake        | payload
//  ---------+------------------+---------------------------------------------
//  command  | i_start, o_busy  | i_cmd, i_point_index, i_coord_*, i_position
//  result   | o_valid          | o_out_x, o_out_y, o_out_z, o_too_few_points
//  config   | i_cfg_we         | i_cfg_index, i_cfg_data
//
// one command is taken every cycle; o_busy stays low
// an evaluate gives its result on o_valid through the registered stages below, a load gives none
// the point store sits in two copies of a 64-entry memory, two read ports each,
// so the four neighbour points of a segment are read in the same cycle
// reset (synchronous, active low) clears the pipeline valids and the registers
`include "cardinal_spline_evaluator_core_defines.svh"
module cardinal_spline_evaluator_core
    import cse_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    output logic         o_busy,
    input  logic         i_cmd,
    input  logic [5:0]   i_point_index,
    input  logic [31:0]  i_coord_x,
    input  logic [31:0]  i_coord_y,
    input  logic [31:0]  i_coord_z,
    input  logic [31:0]  i_position,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [15:0]  i_cfg_data,
    output logic         o_valid,
    output logic [31:0]  o_out_x,
    output logic [31:0]  o_out_y,
    output logic [31:0]  o_out_z,
    output logic         o_too_few_points
);

    // configuration registers
    logic [6:0]  r_point_count;
    logic        r_closed_loop;
    logic [15:0] r_tension_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_point_count <= '0;
            r_closed_loop <= 1'b0;
            r_tension_s   <= TENSION_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POINT_COUNT: r_point_count <= i_cfg_data[6:0];
                REG_CLOSED_LOOP: r_closed_loop <= i_cfg_data[0];
                REG_TENSION_S:   r_tension_s   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_busy = 1'b0;

    logic accept;
    assign accept = i_start && !o_busy;

    // segment selection at the transfer
    logic [CNT_W-1:0]    n_cnt;
    logic [CNT_W-1:0]    segs;
    logic                few;
    logic [16+CNT_W-1:0] scaled;
    logic [CNT_W-1:0]    idx;
    t_addr               n_sel [4];

    always_comb begin
        logic signed [CNT_W+1:0] j;
        if (32'(r_point_count) > MAX_POINTS) n_cnt = CNT_W'(MAX_POINTS);
        else                                 n_cnt = CNT_W'(r_point_count);
        few    = r_closed_loop ? (n_cnt < CNT_W'(3)) : (n_cnt < CNT_W'(2));
        segs   = r_closed_loop ? n_cnt : n_cnt - CNT_W'(1);
        scaled = (16+CNT_W)'(i_position[15:0]) * (16+CNT_W)'(segs);
        idx    = scaled[16+CNT_W-1:16];
        for (int k = 0; k < 4; k++) begin
            j = $signed({2'b00, idx}) + (CNT_W+2)'(k - 1);
            if (r_closed_loop) begin
                if (j < 0)
                    j = j + $signed({2'b00, segs});
                else if (j >= $signed({2'b00, segs}))
                    j = j - $signed({2'b00, segs});
            end else begin
                if (j < 0)
                    j = '0;
                else if (j > $signed({2'b00, n_cnt}) - (CNT_W+2)'(1))
                    j = $signed({2'b00, n_cnt}) - (CNT_W+2)'(1);
            end
            n_sel[k] = PT_AW'(j);
        end
    end

    // stage 1: selected indices and local fraction
    logic        r1_v, r1_tf;
    logic [15:0] r1_u;
    t_addr       r1_sel [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_v <= 1'b0;
        else          r1_v <= accept && (i_cmd == CMD_EVAL);
        r1_tf  <= few;
        r1_u   <= scaled[15:0];
        r1_sel <= n_sel;
    end

    // point store, two copies written together
    logic [95:0] mem_a [MAX_POINTS];
    logic [95:0] mem_b [MAX_POINTS];
    logic [95:0] r_rd [4];

    always_ff @(posedge i_clk) begin
        if (accept && (i_cmd == CMD_LOAD) && (32'(i_point_index) < MAX_POINTS)) begin
            mem_a[PT_AW'(i_point_index)] <= {i_coord_z, i_coord_y, i_coord_x};
            mem_b[PT_AW'(i_point_index)] <= {i_coord_z, i_coord_y, i_coord_x};
        end
        r_rd[0] <= mem_a[r1_sel[0]];
        r_rd[1] <= mem_a[r1_sel[1]];
        r_rd[2] <= mem_b[r1_sel[2]];
        r_rd[3] <= mem_b[r1_sel[3]];
    end

    // stage 2: u squared
    logic        r2_v, r2_tf;
    logic [15:0] r2_u, r2_u2;
    logic [31:0] n_u2;
    assign n_u2 = 32'(r1_u) * 32'(r1_u);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_v <= 1'b0;
        else          r2_v <= r1_v;
        r2_tf <= r1_tf;
        r2_u  <= r1_u;
        r2_u2 <= n_u2[31:16];
    end

    // stage 3: u cubed, point differences
    logic        r3_v, r3_tf;
    logic [15:0] r3_u, r3_u2, r3_u3;
    logic [31:0] n_u3;
    logic signed [32:0] r3_d1 [3];
    logic signed [32:0] r3_d2 [3];
    t_coord      r3_p1 [3];
    t_coord      r3_p2 [3];
    assign n_u3 = 32'(r2_u2) * 32'(r2_u);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_v <= 1'b0;
        else          r3_v <= r2_v;
        r3_tf <= r2_tf;
        r3_u  <= r2_u;
        r3_u2 <= r2_u2;
        r3_u3 <= n_u3[31:16];
        for (int c = 0; c < 3; c++) begin
            r3_p1[c] <= r_rd[1][32*c +: 32];
            r3_p2[c] <= r_rd[2][32*c +: 32];
            r3_d1[c] <= 33'($signed(r_rd[2][32*c +: 32])) - 33'($signed(r_rd[0][32*c +: 32]));
            r3_d2[c] <= 33'($signed(r_rd[3][32*c +: 32])) - 33'($signed(r_rd[1][32*c +: 32]));
        end
    end

    // stage 4: tangents and basis weights
    logic        r4_v, r4_tf;
    logic signed [18:0] r4_h00, r4_h01, r4_h10, r4_h11;
    logic signed [34:0] r4_m1 [3];
    logic signed [34:0] r4_m2 [3];
    t_coord      r4_p1 [3];
    t_coord      r4_p2 [3];
    logic signed [16:0] s_ext;
    logic signed [18:0] u_e, u2_e, u3_e, n_h00;
    assign s_ext = $signed({1'b0, r_tension_s});
    assign u_e   = $signed({3'b000, r3_u});
    assign u2_e  = $signed({3'b000, r3_u2});
    assign u3_e  = $signed({3'b000, r3_u3});
    assign n_h00 = 19'sd2 * u3_e - 19'sd3 * u2_e + 19'sd65536;

    always_ff @(posedge i_clk) begin
        logic signed [49:0] t1, t2;
        if (!i_rst_n) r4_v <= 1'b0;
        else          r4_v <= r3_v;
        r4_tf  <= r3_tf;
        r4_h00 <= n_h00;
        r4_h01 <= 19'sd65536 - n_h00;
        r4_h10 <= u3_e - 19'sd2 * u2_e + u_e;
        r4_h11 <= u3_e - u2_e;
        for (int c = 0; c < 3; c++) begin
            t1 = 50'(s_ext) * 50'(r3_d1[c]);
            t2 = 50'(s_ext) * 50'(r3_d2[c]);
            r4_m1[c] <= t1[49:15];
            r4_m2[c] <= t2[49:15];
            r4_p1[c] <= r3_p1[c];
            r4_p2[c] <= r3_p2[c];
        end
    end

    // stage 5: weighted products
    logic        r5_v, r5_tf;
    logic signed [53:0] r5_a [3];
    logic signed [53:0] r5_b [3];
    logic signed [53:0] r5_c [3];
    logic signed [53:0] r5_d [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r5_v <= 1'b0;
        else          r5_v <= r4_v;
        r5_tf <= r4_tf;
        for (int c = 0; c < 3; c++) begin
            r5_a[c] <= 54'(r4_p1[c]) * 54'(r4_h00);
            r5_b[c] <= 54'(r4_p2[c]) * 54'(r4_h01);
            r5_c[c] <= 54'(r4_m1[c]) * 54'(r4_h10);
            r5_d[c] <= 54'(r4_m2[c]) * 54'(r4_h11);
        end
    end

    // stage 6: sum, round and saturate, or zero when there are too few points
    logic [31:0] n_res [3];

    always_comb begin
        logic signed [55:0] sum;
        logic signed [39:0] q;
        for (int c = 0; c < 3; c++) begin
            sum = 56'(r5_a[c]) + 56'(r5_b[c]) + 56'(r5_c[c]) + 56'(r5_d[c]) + 56'sd32768;
            q   = sum[55:16];
            if (q > 40'sd2147483647)       n_res[c] = 32'h7FFF_FFFF;
            else if (q < -40'sd2147483648) n_res[c] = 32'h8000_0000;
            else                           n_res[c] = q[31:0];
            if (r5_tf) n_res[c] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) o_valid <= 1'b0;
        else          o_valid <= r5_v;
        o_out_x          <= n_res[0];
        o_out_y          <= n_res[1];
        o_out_z          <= n_res[2];
        o_too_few_points <= r5_tf;
    end

    // checks
    `CSE_ASSERT(a_eval_enters, i_clk, i_rst_n, (accept && i_cmd == CMD_EVAL) |=> r1_v)
    `CSE_ASSERT(a_result_source, i_clk, i_rst_n, o_valid |-> $past(accept && i_cmd == CMD_EVAL, LATENCY))
    `CSE_ASSERT_NEVER(a_few_zero, i_clk, i_rst_n, o_valid && o_too_few_points && (o_out_x != 0 || o_out_y != 0 || o_out_z != 0))

endmodule

// ----- tb/cardinal_spline_evaluator_core_tb.sv -----
// testbench for the cardinal spline evaluator: directed and random commands, self-checking
`timescale 1ns / 1ps
module cardinal_spline_evaluator_core_tb;
    import cse_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int WATCHDOG_LIMIT = 5000;

    typedef struct {
        logic        cmd;
        logic [5:0]  slot;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [31:0] pos;
    } t_command;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        few;
    } t_curve_point;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic        i_cmd;
    logic [5:0]  i_point_index;
    logic [31:0] i_coord_x;
    logic [31:0] i_coord_y;
    logic [31:0] i_coord_z;
    logic [31:0] i_position;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;
    logic        o_valid;
    logic [31:0] o_out_x;
    logic [31:0] o_out_y;
    logic [31:0] o_out_z;
    logic        o_too_few_points;

    // predictor copy of store and registers
    t_coord      pts [MAX_POINTS][3];
    logic [6:0]  count_reg;
    logic        closed_reg;
    logic [15:0] tension_reg;

    t_command     pending_cmds[$];
    t_curve_point expected_points[$];
    int           transfers;
    int           quiet_cycles;
    bit           failed;

    cardinal_spline_evaluator_core uut (.*);

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // curve point predicted from the current store and registers
    function automatic t_curve_point eval_curve(logic [31:0] pos);
        t_curve_point r;
        int n, segs, idx, j, k, c;
        int sel[4];
        longint scaled, u, u2, u3, h00, h01, h10, h11, s;
        longint p0, p1, p2, p3, m1, m2, acc, q;
        logic [31:0] v[3];
        n = int'(count_reg);
        if (n > MAX_POINTS) n = MAX_POINTS;
        r.x = '0; r.y = '0; r.z = '0; r.few = 1'b1;
        if (n < (closed_reg ? 3 : 2)) return r;
        segs = closed_reg ? n : n - 1;
        scaled = longint'(pos[15:0]) * segs;
        idx = int'(scaled >>> 16);
        u = scaled & 64'hFFFF;
        for (k = 0; k < 4; k++) begin
            j = idx - 1 + k;
            if (closed_reg) sel[k] = (j + segs) % segs;
            else sel[k] = (j < 0) ? 0 : (j > n - 1) ? n - 1 : j;
        end
        u2 = (u * u) >>> 16;
        u3 = (u2 * u) >>> 16;
        h00 = 2 * u3 - 3 * u2 + 65536;
        h01 = 65536 - h00;
        h10 = u3 - 2 * u2 + u;
        h11 = u3 - u2;
        s = longint'(tension_reg);
        for (c = 0; c < 3; c++) begin
            p0 = longint'(pts[sel[0]][c]);
            p1 = longint'(pts[sel[1]][c]);
            p2 = longint'(pts[sel[2]][c]);
            p3 = longint'(pts[sel[3]][c]);
            m1 = (s * (p2 - p0)) >>> 15;
            m2 = (s * (p3 - p1)) >>> 15;
            acc = p1 * h00 + p2 * h01 + m1 * h10 + m2 * h11;
            q = (acc + 32768) >>> 16;
            if (q > 64'sd2147483647) q = 64'sd2147483647;
            if (q < -64'sd2147483648) q = -64'sd2147483648;
            v[c] = q[31:0];
        end
        r.x = v[0]; r.y = v[1]; r.z = v[2]; r.few = 1'b0;
        return r;
    endfunction

    // idle decision, with a stretch of back-to-back commands
    function automatic bit sender_idles();
        if (transfers >= 200 && transfers < 350) return 1'b0;
        return $urandom_range(99) < 19;
    endfunction

    // driver: one command transfer per start while busy is low
    always @(posedge i_clk) begin
        t_command c;
        bit       take;
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else begin
            take = i_start && !o_busy;
            if (take) begin
                transfers = transfers + 1;
                if (i_cmd == CMD_LOAD) begin
                    pts[i_point_index][0] = i_coord_x;
                    pts[i_point_index][1] = i_coord_y;
                    pts[i_point_index][2] = i_coord_z;
                end else begin
                    expected_points.push_back(eval_curve(i_position));
                end
            end
            if (!i_start || take) begin
                if (pending_cmds.size() > 0 && !sender_idles()) begin
                    c = pending_cmds.pop_front();
                    i_start       <= 1'b1;
                    i_cmd         <= c.cmd;
                    i_point_index <= c.slot;
                    i_coord_x     <= c.cx;
                    i_coord_y     <= c.cy;
                    i_coord_z     <= c.cz;
                    i_position    <= c.pos;
                end else begin
                    i_start <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge i_clk) begin
        t_curve_point e;
        if (i_rst_n && o_valid) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result x=%h y=%h z=%h few=%b",
                         $time, o_out_x, o_out_y, o_out_z, o_too_few_points);
                failed = 1'b1;
            end else begin
                e = expected_points.pop_front();
                if (o_out_x !== e.x) begin
                    $display("%0t: out_x expected %h actual %h", $time, e.x, o_out_x);
                    failed = 1'b1;
                end
                if (o_out_y !== e.y) begin
                    $display("%0t: out_y expected %h actual %h", $time, e.y, o_out_y);
                    failed = 1'b1;
                end
                if (o_out_z !== e.z) begin
                    $display("%0t: out_z expected %h actual %h", $time, e.z, o_out_z);
                    failed = 1'b1;
                end
                if (o_too_few_points !== e.few) begin
                    $display("%0t: too_few_points expected %b actual %b",
                             $time, e.few, o_too_few_points);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid || i_cfg_we) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] pick_coord();
        case ($urandom_range(7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0000_0000;
            3: return 32'hFFFF_FFFF;
            4, 5: return $urandom_range(32'h000F_FFFF) - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic add_load(logic [5:0] slot, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z);
        t_command c;
        c.cmd = CMD_LOAD; c.slot = slot; c.cx = x; c.cy = y; c.cz = z;
        c.pos = $urandom;
        pending_cmds.push_back(c);
    endtask

    task automatic add_eval(logic [31:0] pos);
        t_command c;
        c.cmd = CMD_EVAL; c.slot = 6'($urandom); c.cx = $urandom; c.cy = $urandom;
        c.cz = $urandom; c.pos = pos;
        pending_cmds.push_back(c);
    endtask

    // register write, only issued while the block is idle
    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_POINT_COUNT: count_reg   = data[6:0];
            REG_CLOSED_LOOP: closed_reg  = data[0];
            REG_TENSION_S:   tension_reg = data;
            default: ;
        endcase
    endtask

    // wait for all commands and results, then let the pipeline drain
    task automatic drain();
        @(posedge i_clk);
        #1;
        while (pending_cmds.size() > 0 || i_start || expected_points.size() > 0) begin
            @(posedge i_clk);
            #1;
        end
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic configure(logic [15:0] cnt, logic [15:0] cl, logic [15:0] ten);
        write_reg(REG_POINT_COUNT, cnt);
        write_reg(REG_CLOSED_LOOP, cl);
        write_reg(REG_TENSION_S, ten);
    endtask

    function automatic logic [15:0] pick_count();
        case ($urandom_range(9))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'd2;
            3: return 16'd3;
            4: return 16'd64;
            5: return 16'd65;
            6: return 16'hFFFF;
            7: return 16'd4;
            default: return 16'($urandom_range(2, 64));
        endcase
    endfunction

    function automatic logic [15:0] pick_tension();
        case ($urandom_range(5))
            0: return 16'd0;
            1: return 16'd16384;
            2: return 16'd32768;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // stimulus
    initial begin
        int i, ph;
        i_rst_n = 1'b0; i_start = 1'b0; i_cmd = CMD_LOAD; i_point_index = '0;
        i_coord_x = '0; i_coord_y = '0; i_coord_z = '0; i_position = '0;
        i_cfg_we = 1'b0; i_cfg_index = REG_POINT_COUNT; i_cfg_data = '0;
        count_reg = 7'd0; closed_reg = 1'b0; tension_reg = TENSION_RESET;
        transfers = 0; quiet_cycles = 0; failed = 1'b0;
        for (i = 0; i < MAX_POINTS; i++) begin
            pts[i][0] = '0; pts[i][1] = '0; pts[i][2] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset registers: no points, so too few
        add_eval(32'h0000_8000);
        drain();

        // fill every slot so no read ever hits an unwritten entry
        for (i = 0; i < MAX_POINTS; i++)
            add_load(6'(i), pick_coord(), pick_coord(), pick_coord());
        drain();

        // directed: extremes of counts, loop mode and tension
        configure(16'd2, 16'd0, 16'd16384);
        add_load(6'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        add_load(6'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
        add_eval(32'h0000_0000);
        add_eval(32'hFFFF_FFFF);
        add_eval(32'h8000_8000);
        add_eval(32'h7FFF_4000);
        drain();
        configure(16'd2, 16'd1, 16'd32768);
        add_eval(32'h0000_1234);
        drain();
        configure(16'd3, 16'd1, 16'd0);
        add_eval(32'h0000_0000);
        add_eval(32'h0000_FFFF);
        add_eval(32'h0000_AAAA);
        drain();
        write_reg(REG_UNUSED, 16'hFFFF);
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF);
        add_eval(32'h0000_FFFF);
        add_eval(32'hFFFF_0001);
        drain();
        configure(16'd1, 16'd0, 16'd16384);
        add_eval(32'h0000_5555);
        drain();

        // random phases
        for (ph = 0; ph < 10; ph++) begin
            configure(pick_count(), 16'($urandom), pick_tension());
            if ($urandom_range(3) == 0) write_reg(REG_UNUSED, 16'($urandom));
            for (i = 0; i < 62; i++) begin
                if ($urandom_range(99) < 25)
                    add_load(6'($urandom), pick_coord(), pick_coord(), pick_coord());
                else
                    add_eval($urandom);
            end
            drain();
        end

        if (!failed) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ----- cardinal_spline_evaluator_core.f -----
+incdir+rtl
rtl/cse_pkg.sv
rtl/cardinal_spline_evaluator_core.sv
tb/cardinal_spline_evaluator_core_tb.sv
